/* design/bclp_pkg.sv */
`default_nettype none

package bclp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd1;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* design/bclp_in_if.sv */
`default_nettype none

interface bclp_in_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

`default_nettype wire

/* design/bclp_out_if.sv */
`default_nettype none

interface bclp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] press_event;

    modport source (output valid, output press_event, input ready);
    modport sink   (input valid, input press_event, output ready);
endinterface

`default_nettype wire

/* design/button_click_long_press_classifier.sv */
`default_nettype none

// Debounces an active-low push button and classifies each release as a short
// click or a long press. Every request carries one pin sample and a wrapping
// millisecond timestamp, and yields exactly one result (none, click or long
// press) in the output register on the cycle after it is accepted. One
// request is accepted per clock cycle while not stalled: the state update is
// combinational compares and 32-bit subtractions, and the output register
// lets a new request in while the previous result is being taken.
// Configuration writes (index 0 debounce time, index 1 long-press time) take
// effect on the next clock edge and must be made while the block is idle.
module button_click_long_press_classifier (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [bclp_pkg::CFG_W-1:0]  i_cfg_data,
    bclp_in_if.sink                          i_item,
    bclp_out_if.source                       o_result
);
    import bclp_pkg::*;

    t_cfg   r_cfg;
    t_event step_event;
    logic   accept;
    logic   r_out_valid;
    logic [1:0] r_out_event;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default:        r_cfg               <= r_cfg;
            endcase
        end
    end

    bclp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_pin_level (i_item.pin_level),
        .i_now_ms    (i_item.now_ms),
        .i_cfg       (r_cfg),
        .o_event     (step_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_event <= step_event;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.press_event = r_out_event;

endmodule

`default_nettype wire

/* design/bclp_core.sv */
`default_nettype none

module bclp_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_pin_level,
    input  wire logic [bclp_pkg::TIME_W-1:0]   i_now_ms,
    input  wire bclp_pkg::t_cfg                i_cfg,
    output bclp_pkg::t_event                   o_event
);
    import bclp_pkg::*;

    logic              r_previous_raw;
    logic              r_stable_level;
    logic [TIME_W-1:0] r_change_time;
    logic [TIME_W-1:0] r_press_start;
    logic              r_press_pending;

    logic              n_stable_level;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] n_press_start;
    logic              n_press_pending;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] hold_time;
    logic              adopt;

    // A raw change in this sample fails the match with the previous raw level,
    // so the level is never adopted in the same sample in which it changed.
    assign since_change = i_now_ms - r_change_time;
    assign hold_time    = i_now_ms - r_press_start;
    assign adopt = (i_pin_level == r_previous_raw)
                && (since_change > {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms})
                && (i_pin_level != r_stable_level);

    always_comb begin
        n_change_time   = (i_pin_level != r_previous_raw) ? i_now_ms : r_change_time;
        n_stable_level  = r_stable_level;
        n_press_start   = r_press_start;
        n_press_pending = r_press_pending;
        o_event         = EV_NONE;
        if (adopt) begin
            n_stable_level = i_pin_level;
            if (!i_pin_level) begin
                n_press_start   = i_now_ms;
                n_press_pending = 1'b1;
            end else if (r_press_pending) begin
                // A release without a recorded press reports nothing.
                if (hold_time < {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms}) begin
                    o_event = EV_CLICK;
                end else begin
                    o_event = EV_LONG;
                end
                n_press_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_raw  <= 1'b0;
            r_stable_level  <= 1'b0;
            r_change_time   <= '0;
            r_press_start   <= '0;
            r_press_pending <= 1'b0;
        end else if (i_step) begin
            r_previous_raw  <= i_pin_level;
            r_stable_level  <= n_stable_level;
            r_change_time   <= n_change_time;
            r_press_start   <= n_press_start;
            r_press_pending <= n_press_pending;
        end
    end

endmodule

`default_nettype wire
